// ===== hdl/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared constants, types and codes of the text console character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // video memory and screen geometry
  localparam int VRAM_WORDS  = 8192;
  localparam int VRAM_AW     = $clog2(VRAM_WORDS);
  localparam int LINE_CHARS  = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int ROW_W       = $clog2(SCREEN_ROWS);
  localparam int COL_W       = $clog2(LINE_CHARS);
  localparam int COPY_WORDS  = (SCREEN_ROWS - 1) * LINE_CHARS;
  localparam int FIT_SPAN    = SCREEN_ROWS * LINE_CHARS + LINE_CHARS;
  localparam int DATA_W      = 16;
  localparam int CHAR_W      = 8;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // word values and character codes
  localparam logic [DATA_W-1:0] BLANK_WORD   = 16'h0700;
  localparam logic [DATA_W-1:0] SCROLL_FILL  = 16'h0C00;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] TEXT_COLOR_RESET = 8'd10;

  // register port
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_TEXT_COLOR = 1'b0;

  // action field codes
  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_NEWLINE,
    CMD_RETURN,
    CMD_BACKSPACE,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [CHAR_W-1:0]    chr;
    logic [VRAM_AW-1:0]   addr;
  } cmd_t;

  typedef struct packed {
    logic                 we;
    logic [VRAM_AW-1:0]   addr;
    logic [DATA_W-1:0]    data;
  } ram_wr_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL,
    ST_DONE
  } back_state_t;

endpackage

// ===== hdl/tcce_if.sv =====
// ----------------------------------------------------------------------------
// tcce_in_if / tcce_out_if
// Valid/ready channels for character transactions and result transactions.
// ----------------------------------------------------------------------------
interface tcce_in_if import tcce_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [CHAR_W-1:0]  char_code;
  logic [VRAM_AW-1:0] read_address;

  modport source (output valid, action, char_code, read_address, input ready);
  modport sink   (input valid, action, char_code, read_address, output ready);
endinterface

interface tcce_out_if import tcce_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VRAM_AW-1:0] cursor_position;
  logic [VRAM_AW-1:0] display_origin;
  logic               origin_changed;
  logic [DATA_W-1:0]  read_data;

  modport source (output valid, cursor_position, display_origin, origin_changed, read_data,
                  input ready);
  modport sink   (input valid, cursor_position, display_origin, origin_changed, read_data,
                  output ready);
endinterface

// ===== hdl/text_console_char_engine_top.sv =====
// ----------------------------------------------------------------------------
// text_console_char_engine_top
// 80x25 text console engine over an internal 8192-word video memory.
// ----------------------------------------------------------------------------
// After reset the engine clears all 8192 video words to 0x0700, one word per
// cycle, so char_in.ready stays low until the clear is done (register
// writes are taken throughout). A front stage decodes each character
// transaction and places it in a two-entry command queue; a back stage
// executes commands against the cursor, the display origin and the video
// memory (one write port, one registered read port). Put, newline without
// scroll, return and backspace are executed without leaving the idle state,
// so they can run at one transaction per cycle when the result is taken at
// once. A read transaction passes through a read state because the memory
// read is registered. A scroll that still fits in memory writes the new
// bottom row; a scroll that wraps first copies rows 1..24 to the start of
// memory, one word per cycle, then fills the bottom row. Backspace at column
// zero is consumed with no result.
// ----------------------------------------------------------------------------
module text_console_char_engine_top import tcce_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  tcce_in_if.sink            char_in,
  tcce_out_if.source         result_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  logic [CHAR_W-1:0]  text_color;
  logic               accept_en;
  logic               cmd_valid;
  cmd_t               cmd;
  logic               cmd_pop;
  ram_wr_t            ram_wr;
  logic [VRAM_AW-1:0] ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;
  logic [REG_IDX_W-1:0] reg_idx;

  // register port: byte address 4*i selects register i
  assign reg_idx = paddr[APB_AW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= TEXT_COLOR_RESET;
    end else if (psel && penable && pwrite && (reg_idx == REG_TEXT_COLOR)) begin
      text_color <= pwdata[CHAR_W-1:0];
    end
  end

  // read back the attribute byte, zero elsewhere
  assign prdata = (reg_idx == REG_TEXT_COLOR) ? APB_DW'(text_color) : '0;

  // decode and queue incoming transactions
  tcce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept_en (accept_en),
    .in_ch     (char_in),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // command execution, scroll sequencing and result register
  tcce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .text_color (text_color),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .accept_en  (accept_en),
    .ram_wr     (ram_wr),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .result     (result_out)
  );

  // video memory
  tcce_ram #(
    .WIDTH (DATA_W),
    .DEPTH (VRAM_WORDS)
  ) u_vram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== hdl/tcce_ram.sv =====
// ----------------------------------------------------------------------------
// tcce_ram
// Generic single-write, single-read RAM with registered, write-first read.
// ----------------------------------------------------------------------------
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/tcce_front.sv =====
// ----------------------------------------------------------------------------
// tcce_front
// Accepts character transactions, decodes them and queues the commands.
// ----------------------------------------------------------------------------
module tcce_front import tcce_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept_en,
  tcce_in_if.sink   in_ch,
  output logic      cmd_valid,
  output cmd_t      cmd,
  input  logic      cmd_pop
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  cmd_t              decoded;
  logic              push;

  // classify the incoming transaction
  always_comb begin
    decoded.chr  = in_ch.char_code;
    decoded.addr = in_ch.read_address;
    priority if (in_ch.action == ACT_READ) begin
      decoded.kind = CMD_READ;
    end else if (in_ch.char_code == CH_NEWLINE) begin
      decoded.kind = CMD_NEWLINE;
    end else if (in_ch.char_code == CH_RETURN) begin
      decoded.kind = CMD_RETURN;
    end else if (in_ch.char_code == CH_BACKSPACE) begin
      decoded.kind = CMD_BACKSPACE;
    end else begin
      decoded.kind = CMD_PUT;
    end
  end

  assign in_ch.ready = accept_en && (count != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (count != '0);
  assign cmd         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !cmd_pop) begin
        count <= count + 1'b1;
      end else if (!push && cmd_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/tcce_back.sv =====
// ----------------------------------------------------------------------------
// tcce_back
// Executes queued commands: cursor state, video memory writes, scrolling,
// memory clearing after reset and the result register.
// ----------------------------------------------------------------------------
module tcce_back import tcce_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [CHAR_W-1:0]  text_color,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  output logic               accept_en,
  output ram_wr_t            ram_wr,
  output logic [VRAM_AW-1:0] ram_raddr,
  input  logic [DATA_W-1:0]  ram_rdata,
  tcce_out_if.source         result
);

  localparam logic [ROW_W-1:0]   LAST_ROW = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [COL_W-1:0]   LAST_COL = COL_W'(LINE_CHARS - 1);
  localparam logic [VRAM_AW-1:0] LINE_W   = VRAM_AW'(LINE_CHARS);

  back_state_t        state, state_next;
  logic [VRAM_AW-1:0] cnt, cnt_next;
  logic [VRAM_AW-1:0] base, base_next;
  logic [VRAM_AW-1:0] origin, origin_next;
  logic [ROW_W-1:0]   row, row_next;
  logic [COL_W-1:0]   col, col_next;

  logic               res_valid;
  logic [VRAM_AW-1:0] res_cursor;
  logic [VRAM_AW-1:0] res_origin;
  logic               res_changed;
  logic [DATA_W-1:0]  res_rdata;

  logic               load;
  logic               ld_changed;
  logic [DATA_W-1:0]  ld_rdata;
  logic               out_free;
  logic               fits;
  logic [VRAM_AW-1:0] cur_addr;
  logic [VRAM_AW-1:0] nxt_addr;
  logic [VRAM_AW-1:0] origin_adv;

  assign cur_addr   = origin + VRAM_AW'(row) * LINE_W + VRAM_AW'(col);
  assign nxt_addr   = origin_next + VRAM_AW'(row_next) * LINE_W + VRAM_AW'(col_next);
  assign origin_adv = origin + LINE_W;
  assign fits       = ({1'b0, origin} + (VRAM_AW + 1)'(FIT_SPAN))
                      <= (VRAM_AW + 1)'(VRAM_WORDS - 1);
  assign out_free   = !res_valid || result.ready;
  assign accept_en  = (state != ST_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      cnt    <= '0;
      origin <= '0;
      row    <= '0;
      col    <= '0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      origin <= origin_next;
      row    <= row_next;
      col    <= col_next;
    end
  end

  always_ff @(posedge clk) begin
    base <= base_next;
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    base_next   = base;
    origin_next = origin;
    row_next    = row;
    col_next    = col;
    cmd_pop     = 1'b0;
    ram_wr      = '0;
    ram_raddr   = cmd.addr;
    load        = 1'b0;
    ld_changed  = 1'b0;
    ld_rdata    = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = cnt;
        ram_wr.data = BLANK_WORD;
        if (cnt == VRAM_AW'(VRAM_WORDS - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          // row advance out of newline or column wrap
          if ((cmd.kind == CMD_NEWLINE) ||
              ((cmd.kind == CMD_PUT) && (col == LAST_COL))) begin
            if (row == LAST_ROW) begin
              cnt_next = '0;
              if (fits) begin
                origin_next = origin_adv;
                base_next   = origin_adv + VRAM_AW'(COPY_WORDS);
                state_next  = ST_FILL;
              end else begin
                origin_next = '0;
                base_next   = origin_adv;
                state_next  = ST_COPY;
              end
            end else begin
              row_next = row + 1'b1;
              load     = 1'b1;
            end
          end
          unique case (cmd.kind)
            CMD_READ: begin
              state_next = ST_READ;
            end
            CMD_NEWLINE: begin
            end
            CMD_RETURN: begin
              col_next = '0;
              load     = 1'b1;
            end
            CMD_BACKSPACE: begin
              if (col != '0) begin
                col_next    = col - 1'b1;
                ram_wr.we   = 1'b1;
                ram_wr.addr = cur_addr - 1'b1;
                ram_wr.data = BLANK_WORD;
                load        = 1'b1;
              end
            end
            CMD_PUT: begin
              ram_wr.we   = 1'b1;
              ram_wr.addr = cur_addr;
              ram_wr.data = {text_color, cmd.chr};
              if (col == LAST_COL) begin
                col_next = '0;
              end else begin
                col_next = col + 1'b1;
                load     = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        load       = 1'b1;
        ld_rdata   = ram_rdata;
        state_next = ST_IDLE;
      end
      ST_COPY: begin
        // read one word ahead, write the previous one
        ram_raddr = base + cnt;
        if (cnt != '0) begin
          ram_wr.we   = 1'b1;
          ram_wr.addr = cnt - 1'b1;
          ram_wr.data = ram_rdata;
        end
        if (cnt == VRAM_AW'(COPY_WORDS)) begin
          cnt_next   = '0;
          base_next  = VRAM_AW'(COPY_WORDS);
          state_next = ST_FILL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_FILL: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = base + cnt;
        ram_wr.data = SCROLL_FILL;
        if (cnt == VRAM_AW'(LINE_CHARS - 1)) begin
          cnt_next   = '0;
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DONE: begin
        load       = 1'b1;
        ld_changed = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_cursor  <= nxt_addr;
      res_origin  <= origin_next;
      res_changed <= ld_changed;
      res_rdata   <= ld_rdata;
    end
  end

  assign result.valid           = res_valid;
  assign result.cursor_position = res_cursor;
  assign result.display_origin  = res_origin;
  assign result.origin_changed  = res_changed;
  assign result.read_data       = res_rdata;

endmodule

// ===== tb/text_console_char_engine_top_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_char_engine_top_tb
// Self-checking bench for the text console engine: a table of directed
// character and read transactions, then random text lines, newline runs,
// reads and noise over several text colors. A shadow console with its own
// cursor, origin and video memory predicts every result but those of fixed rows.
// ----------------------------------------------------------------------------
module text_console_char_engine_top_tb;
  import tcce_pkg::*;

  // one result transaction as the engine reports it
  typedef struct packed {
    logic [VRAM_AW-1:0] cursor;
    logic [VRAM_AW-1:0] origin;
    logic               changed;
    logic [DATA_W-1:0]  data;
  } console_result_t;

  // one row of the directed table; fixed rows carry a typed-in answer
  typedef struct {
    logic               act;
    logic [CHAR_W-1:0]  chr;
    logic [VRAM_AW-1:0] addr;
    int unsigned        reps;
    bit                 fixed;
    bit                 has_res;
    console_result_t    res;
  } stim_row_t;

  localparam int unsigned WORD_MASK   = VRAM_WORDS - 1;
  localparam int unsigned BYTE_MASK   = 2 * VRAM_WORDS - 1;
  localparam int unsigned LINE_BYTES  = 2 * LINE_CHARS;
  localparam int unsigned SCRN_BYTES  = 2 * SCREEN_ROWS * LINE_CHARS;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned NUM_PHASES  = 6;
  localparam int unsigned PHASE_ITEMS = 85;
  localparam int unsigned SETTLE      = 16;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  tcce_in_if  char_if ();
  tcce_out_if res_if ();

  text_console_char_engine_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .char_in    (char_if),
    .result_out (res_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow console state
  logic [CHAR_W-1:0] shadow_color;
  int unsigned       shadow_row;
  int unsigned       shadow_col;
  int unsigned       shadow_origin;   // byte offset; the engine keeps a word address
  logic [DATA_W-1:0] shadow_vram [VRAM_WORDS];

  console_result_t pending_results [$];
  int unsigned     results_due;
  int unsigned     err_count;

  // what the sender currently offers beyond the channel payload
  bit              cur_fixed;
  bit              cur_fixed_has;
  console_result_t cur_fixed_res;

  // idling controls shared by sender and receiver
  bit hold_req;
  bit steady;

  // monitor scratch
  bit              step_has;
  console_result_t step_res;
  console_result_t seen_res;
  console_result_t want_res;

  // --------------------------------------------------------------------------
  // shadow console
  // --------------------------------------------------------------------------
  function automatic logic [VRAM_AW-1:0] cursor_word();
    int unsigned b;
    b = (shadow_origin + 2 * (shadow_row * LINE_CHARS + shadow_col)) & BYTE_MASK;
    return VRAM_AW'(b >> 1);
  endfunction

  // one line up: slide the origin while the screen fits, else copy to the top
  task automatic scroll_screen();
    int unsigned src;
    int unsigned bottom;
    if (shadow_origin + SCRN_BYTES + LINE_BYTES <= BYTE_MASK) begin
      shadow_origin = (shadow_origin + LINE_BYTES) & BYTE_MASK;
    end else begin
      src = (shadow_origin + LINE_BYTES) >> 1;
      for (int unsigned i = 0; i < COPY_WORDS; i++)
        shadow_vram[i] = shadow_vram[(src + i) & WORD_MASK];
      shadow_origin = 0;
    end
    bottom = (shadow_origin >> 1) + COPY_WORDS;
    for (int unsigned i = 0; i < LINE_CHARS; i++)
      shadow_vram[(bottom + i) & WORD_MASK] = SCROLL_FILL;
  endtask

  task automatic next_row(output bit scrolled);
    scrolled = 1'b0;
    shadow_row++;
    if (shadow_row >= SCREEN_ROWS) begin
      shadow_row = SCREEN_ROWS - 1;
      scroll_screen();
      scrolled = 1'b1;
    end
  endtask

  task automatic console_step(input logic act, input logic [CHAR_W-1:0] ch,
                              input logic [VRAM_AW-1:0] addr,
                              output bit produced, output console_result_t r);
    bit                scrolled;
    logic [DATA_W-1:0] rdata;
    produced = 1'b1;
    scrolled = 1'b0;
    rdata    = '0;
    if (act == ACT_READ) begin
      rdata = shadow_vram[addr];
    end else begin
      case (ch)
        CH_NEWLINE: next_row(scrolled);
        CH_RETURN: shadow_col = 0;
        CH_BACKSPACE: begin
          // at column zero the character is swallowed
          if (shadow_col == 0) begin
            produced = 1'b0;
          end else begin
            shadow_col--;
            shadow_vram[cursor_word()] = BLANK_WORD;
          end
        end
        default: begin
          shadow_vram[cursor_word()] = {shadow_color, ch};
          shadow_col++;
          if (shadow_col >= LINE_CHARS) begin
            shadow_col = 0;
            next_row(scrolled);
          end
        end
      endcase
    end
    r.cursor  = cursor_word();
    r.origin  = VRAM_AW'(shadow_origin >> 1);
    r.changed = scrolled;
    r.data    = rdata;
  endtask

  // --------------------------------------------------------------------------
  // monitor: input acceptance first, then result acceptance, in one process
  // so a result can never be checked before its expectation is queued
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (char_if.valid && char_if.ready) begin
        console_step(char_if.action, char_if.char_code, char_if.read_address,
                     step_has, step_res);
        if (cur_fixed) begin
          if (cur_fixed_has) begin
            pending_results.push_back(cur_fixed_res);
            results_due++;
          end
        end else if (step_has) begin
          pending_results.push_back(step_res);
          results_due++;
        end
      end
      if (res_if.valid && res_if.ready) begin
        seen_res = {res_if.cursor_position, res_if.display_origin,
                    res_if.origin_changed, res_if.read_data};
        if (pending_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result transaction: cursor %0d origin %0d chg %0b data %h",
                     seen_res.cursor, seen_res.origin, seen_res.changed, seen_res.data);
        end else begin
          want_res = pending_results.pop_front();
          if (seen_res.cursor !== want_res.cursor || seen_res.origin !== want_res.origin ||
              seen_res.changed !== want_res.changed || seen_res.data !== want_res.data) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: cursor %0d/%0d origin %0d/%0d chg %0b/%0b data %h/%h (exp/got)",
                       want_res.cursor, seen_res.cursor, want_res.origin, seen_res.origin,
                       want_res.changed, seen_res.changed, want_res.data, seen_res.data);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // idling
  // --------------------------------------------------------------------------
  // mostly no gap, some short ones, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (steady || p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result receiver: random stalls, one long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold-off so the engine fills up and pushes back on its input
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (!steady && $urandom_range(0, 99) < 35) begin
        res_if.ready = 1'b0;
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 50) : $urandom_range(1, 3))
          @(negedge clk);
      end else begin
        res_if.ready = 1'b1;
        repeat ($urandom_range(1, 20) - 1) @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------
  // offer one character transaction and wait until it is taken; starts and
  // ends on a falling edge, valid stays high across back-to-back transactions
  task automatic send_char(input logic act, input logic [CHAR_W-1:0] ch,
                           input logic [VRAM_AW-1:0] addr, input bit fixed = 1'b0,
                           input bit fixed_has = 1'b0, input console_result_t fixed_res = '0);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      char_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_if.action       = act;
    char_if.char_code    = ch;
    char_if.read_address = addr;
    cur_fixed            = fixed;
    cur_fixed_has        = fixed_has;
    cur_fixed_res        = fixed_res;
    char_if.valid        = 1'b1;
    do @(posedge clk); while (!char_if.ready);
    @(negedge clk);
  endtask

  // register write: setup cycle, then access until pready
  task automatic write_color(input logic [CHAR_W-1:0] color);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {REG_TEXT_COLOR, 2'b00};
    pwdata  = {{(APB_DW-CHAR_W){1'b0}}, color};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    shadow_color = color;
  endtask

  // sender pause: every expected result back, then room for swallowed items
  task automatic drain();
    char_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] printable_byte();
    logic [CHAR_W-1:0] c;
    c = CHAR_W'($urandom);
    while (c == CH_NEWLINE || c == CH_RETURN || c == CH_BACKSPACE) c = CHAR_W'($urandom);
    return c;
  endfunction

  // one random stretch of console traffic
  task automatic run_segment();
    int unsigned kind;
    int unsigned len;
    logic [VRAM_AW-1:0] a;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      // a line of text, sometimes long enough to wrap, then usually CR, then LF
      len = ($urandom_range(0, 99) < 15) ? $urandom_range(60, 100) : $urandom_range(0, 30);
      repeat (len) send_char(ACT_PUT, printable_byte(), VRAM_AW'($urandom));
      if ($urandom_range(0, 99) < 30)
        repeat ($urandom_range(1, 4)) send_char(ACT_PUT, CH_BACKSPACE, VRAM_AW'($urandom));
      if ($urandom_range(0, 99) < 80) send_char(ACT_PUT, CH_RETURN, VRAM_AW'($urandom));
      send_char(ACT_PUT, CH_NEWLINE, VRAM_AW'($urandom));
    end else if (kind < 65) begin
      // run of newlines drives the origin toward the wrap-around copy
      repeat ($urandom_range(10, 40))
        send_char(ACT_PUT, ($urandom_range(0, 9) == 0) ? CH_RETURN : CH_NEWLINE,
                  VRAM_AW'($urandom));
    end else if (kind < 85) begin
      // reads: anywhere, at the cursor, or on the visible screen
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 2))
          0: a = VRAM_AW'($urandom);
          1: a = cursor_word();
          default: a = VRAM_AW'((shadow_origin >> 1) +
                                $urandom_range(0, SCREEN_ROWS * LINE_CHARS - 1));
        endcase
        send_char(ACT_READ, CHAR_W'($urandom), a);
      end
    end else begin
      // noise: any action, control codes mixed with arbitrary bytes
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 3))
          0: send_char(1'($urandom), CH_BACKSPACE, VRAM_AW'($urandom));
          1: send_char(1'($urandom), CH_NEWLINE, VRAM_AW'($urandom));
          2: send_char(1'($urandom), CH_RETURN, VRAM_AW'($urandom));
          default: send_char(1'($urandom), CHAR_W'($urandom), VRAM_AW'($urandom));
        endcase
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // directed table, reset color 10
  // --------------------------------------------------------------------------
  stim_row_t directed_rows [0:23] = '{
    // reads right after reset see the cleared memory
    '{ACT_READ, 8'h00, 13'h0000, 1, 1'b1, 1'b1, '{13'd0, 13'd0, 1'b0, 16'h0700}},
    '{ACT_READ, 8'hFF, 13'h1FFF, 1, 1'b1, 1'b1, '{13'd0, 13'd0, 1'b0, 16'h0700}},
    // backspace at column zero is swallowed
    '{ACT_PUT, CH_BACKSPACE, 13'h0000, 1, 1'b1, 1'b0, '0},
    // printable bytes including zero, top-bit-set and all ones
    '{ACT_PUT, 8'h41, 13'h0000, 1, 1'b1, 1'b1, '{13'd1, 13'd0, 1'b0, 16'h0000}},
    '{ACT_PUT, 8'h00, 13'h1FFF, 1, 1'b1, 1'b1, '{13'd2, 13'd0, 1'b0, 16'h0000}},
    '{ACT_PUT, 8'hFF, 13'h0000, 1, 1'b1, 1'b1, '{13'd3, 13'd0, 1'b0, 16'h0000}},
    '{ACT_PUT, 8'h80, 13'h0000, 1, 1'b1, 1'b1, '{13'd4, 13'd0, 1'b0, 16'h0000}},
    '{ACT_READ, 8'h00, 13'h0000, 1, 1'b1, 1'b1, '{13'd4, 13'd0, 1'b0, 16'h0A41}},
    '{ACT_READ, 8'h00, 13'h0002, 1, 1'b1, 1'b1, '{13'd4, 13'd0, 1'b0, 16'h0AFF}},
    // backspace blanks the cell it lands on
    '{ACT_PUT, CH_BACKSPACE, 13'h0000, 1, 1'b1, 1'b1, '{13'd3, 13'd0, 1'b0, 16'h0000}},
    '{ACT_READ, 8'h00, 13'h0003, 1, 1'b1, 1'b1, '{13'd3, 13'd0, 1'b0, 16'h0700}},
    '{ACT_PUT, CH_RETURN, 13'h0000, 1, 1'b1, 1'b1, '{13'd0, 13'd0, 1'b0, 16'h0000}},
    '{ACT_PUT, CH_NEWLINE, 13'h0000, 1, 1'b1, 1'b1, '{13'd80, 13'd0, 1'b0, 16'h0000}},
    // read ignores the character byte, put ignores the address
    '{ACT_READ, 8'hAA, 13'h1555, 1, 1'b0, 1'b0, '0},
    '{ACT_READ, CH_NEWLINE, 13'h0AAA, 1, 1'b0, 1'b0, '0},
    '{ACT_PUT, CH_RETURN, 13'h1FFF, 1, 1'b0, 1'b0, '0},
    '{ACT_PUT, 8'h7F, 13'h1555, 1, 1'b0, 1'b0, '0},
    '{ACT_PUT, CH_RETURN, 13'h0AAA, 1, 1'b0, 1'b0, '0},
    // down to the last row, then the first scroll
    '{ACT_PUT, CH_NEWLINE, 13'h0000, 23, 1'b0, 1'b0, '0},
    '{ACT_PUT, CH_NEWLINE, 13'h0000, 1, 1'b1, 1'b1, '{13'd2000, 13'd80, 1'b1, 16'h0000}},
    '{ACT_READ, 8'h00, 13'd2000, 1, 1'b1, 1'b1, '{13'd2000, 13'd80, 1'b0, 16'h0C00}},
    '{ACT_READ, 8'h00, 13'd80, 1, 1'b0, 1'b0, '0},
    '{ACT_PUT, CH_BACKSPACE, 13'h0000, 1, 1'b0, 1'b0, '0},
    '{ACT_PUT, 8'h55, 13'h0000, 1, 1'b0, 1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [CHAR_W-1:0] color_plan [NUM_PHASES];
    int unsigned       phase_start;

    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    char_if.valid        = 1'b0;
    char_if.action       = ACT_PUT;
    char_if.char_code    = '0;
    char_if.read_address = '0;
    cur_fixed            = 1'b0;
    cur_fixed_has        = 1'b0;
    cur_fixed_res        = '0;
    hold_req             = 1'b0;
    steady               = 1'b0;
    results_due          = 0;
    err_count            = 0;
    shadow_color         = TEXT_COLOR_RESET;
    shadow_row           = 0;
    shadow_col           = 0;
    shadow_origin        = 0;
    for (int i = 0; i < VRAM_WORDS; i++) shadow_vram[i] = BLANK_WORD;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part; the engine clears its memory first, the sender just waits
    foreach (directed_rows[k])
      repeat (directed_rows[k].reps)
        send_char(directed_rows[k].act, directed_rows[k].chr, directed_rows[k].addr,
                  directed_rows[k].fixed, directed_rows[k].has_res, directed_rows[k].res);
    drain();

    // random phases, each under its own text color; extremes first
    color_plan[0] = 8'h00;
    color_plan[1] = 8'hFF;
    for (int p = 2; p < NUM_PHASES; p++) color_plan[p] = CHAR_W'($urandom);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_color(color_plan[p]);
      hold_req    = (p == 0);
      steady      = (p == 2);
      phase_start = results_due;
      while (results_due - phase_start < PHASE_ITEMS) run_segment();
      drain();
    end

    steady = 1'b0;
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
